[sv/i2sfd_pkg.sv]
`timescale 1ns / 1ps
// i2sfd_pkg: shared widths, constants, handshake structs and band lookups
// for the i2s format detector; no dependencies

package i2sfd_pkg;

    // edge counter width
    localparam int COUNT_WIDTH = 20;
    // widths fixed by the register and result fields
    localparam int WPS_W  = 10;
    localparam int RATE_W = 17;
    localparam int BITS_W = 6;
    // scaled count width: count times windows per second
    localparam int PROD_W = COUNT_WIDTH + WPS_W;
    // divider step counter
    localparam int STEP_W = $clog2(COUNT_WIDTH);

    localparam logic [WPS_W-1:0] WPS_RESET = WPS_W'(20);

    // sample rate band edges, in edges per second
    localparam int BAND_11K_LO = 9512;
    localparam int BAND_16K_LO = 13512;
    localparam int BAND_22K_LO = 19025;
    localparam int BAND_32K_LO = 27025;
    localparam int BAND_44K_LO = 38050;
    localparam int BAND_48K_LO = 46050;
    localparam int BAND_48K_HI = 69075;
    localparam int BAND_88K_LO = 68100;
    localparam int BAND_96K_LO = 92100;

    // standard rates
    localparam logic [RATE_W-1:0] RATE_8K  = RATE_W'(8000);
    localparam logic [RATE_W-1:0] RATE_11K = RATE_W'(11025);
    localparam logic [RATE_W-1:0] RATE_16K = RATE_W'(16000);
    localparam logic [RATE_W-1:0] RATE_22K = RATE_W'(22050);
    localparam logic [RATE_W-1:0] RATE_32K = RATE_W'(32000);
    localparam logic [RATE_W-1:0] RATE_44K = RATE_W'(44100);
    localparam logic [RATE_W-1:0] RATE_48K = RATE_W'(48000);
    localparam logic [RATE_W-1:0] RATE_88K = RATE_W'(88200);
    localparam logic [RATE_W-1:0] RATE_96K = RATE_W'(96000);

    // bits per sample thresholds on the halved ratio
    localparam int RATIO_32 = 26;
    localparam int RATIO_24 = 22;
    localparam int RATIO_16 = 12;

    localparam logic [BITS_W-1:0] BITS_NONE = BITS_W'(0);
    localparam logic [BITS_W-1:0] BITS_8    = BITS_W'(8);
    localparam logic [BITS_W-1:0] BITS_16   = BITS_W'(16);
    localparam logic [BITS_W-1:0] BITS_24   = BITS_W'(24);
    localparam logic [BITS_W-1:0] BITS_32   = BITS_W'(32);

    // controller to datapath commands
    typedef struct packed {
        logic count;    // tick transfer, count its edges
        logic capture;  // window closes, snapshot and clear counters
        logic step;     // one divider iteration
        logic finish;   // load result register and history
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last; // current step is the final divider iteration
        logic out_free; // result register can take a new result
    } status_t;

    // map scaled word select count to a standard rate, first match wins
    function automatic logic [RATE_W-1:0] rate_band(input logic [PROD_W-1:0] s);
        logic [RATE_W-1:0] r;
        r = RATE_8K;
        priority if (s >= PROD_W'(BAND_11K_LO) && s < PROD_W'(BAND_16K_LO)) r = RATE_11K;
        else if (s >= PROD_W'(BAND_16K_LO) && s < PROD_W'(BAND_22K_LO)) r = RATE_16K;
        else if (s >= PROD_W'(BAND_22K_LO) && s < PROD_W'(BAND_32K_LO)) r = RATE_22K;
        else if (s >= PROD_W'(BAND_32K_LO) && s < PROD_W'(BAND_44K_LO)) r = RATE_32K;
        else if (s >= PROD_W'(BAND_44K_LO) && s < PROD_W'(BAND_48K_LO)) r = RATE_44K;
        else if (s >= PROD_W'(BAND_48K_LO) && s < PROD_W'(BAND_48K_HI)) r = RATE_48K;
        else if (s >= PROD_W'(BAND_88K_LO) && s < PROD_W'(BAND_96K_LO)) r = RATE_88K;
        else if (s >= PROD_W'(BAND_96K_LO)) r = RATE_96K;
        else r = RATE_8K;
        return r;
    endfunction

    // quantize bits per sample from the full quotient (halving folded in)
    function automatic logic [BITS_W-1:0] bits_band(input logic [COUNT_WIDTH-1:0] q);
        logic [COUNT_WIDTH-2:0] r;
        logic [BITS_W-1:0]      b;
        r = q[COUNT_WIDTH-1:1];
        priority if (r >= (COUNT_WIDTH-1)'(RATIO_32)) b = BITS_32;
        else if (r >= (COUNT_WIDTH-1)'(RATIO_24)) b = BITS_24;
        else if (r >= (COUNT_WIDTH-1)'(RATIO_16)) b = BITS_16;
        else b = BITS_8;
        return b;
    endfunction

endpackage

[sv/i2sfd_if.sv]
`timescale 1ns / 1ps
// i2sfd_in_if / i2sfd_out_if: valid/ready channels for edge ticks and results
// depends on i2sfd_pkg for field widths

interface i2sfd_in_if;
    logic valid;
    logic ready;
    logic bit_clock_edge;
    logic word_select_edge;
    logic window_end;

    modport source (output valid, output bit_clock_edge, output word_select_edge,
                    output window_end, input ready);
    modport sink   (input valid, input bit_clock_edge, input word_select_edge,
                    input window_end, output ready);
endinterface

interface i2sfd_out_if;
    logic                              valid;
    logic                              ready;
    logic [i2sfd_pkg::RATE_W-1:0]      sample_rate_hz;
    logic [i2sfd_pkg::BITS_W-1:0]      bits_per_sample;
    logic                              changed;

    modport source (output valid, output sample_rate_hz, output bits_per_sample,
                    output changed, input ready);
    modport sink   (input valid, input sample_rate_hz, input bits_per_sample,
                    input changed, output ready);
endinterface

[sv/i2sfd_ctrl.sv]
`timescale 1ns / 1ps
// i2sfd_ctrl: sequencer for counting, divide and result load
// depends on i2sfd_pkg

module i2sfd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_window_end,
    output logic               in_ready,
    input  i2sfd_pkg::status_t status,
    output i2sfd_pkg::cmd_t    cmd
);
    import i2sfd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // tick transfers only while counting
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // command decode
    always_comb
    begin
        cmd         = '0;
        cmd.count   = accept;
        cmd.capture = accept && in_window_end;
        cmd.step    = (state_reg == ST_DIV);
        cmd.finish  = (state_reg == ST_DONE) && status.out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_window_end)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // a window end leads straight into the divide
    a_capture_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_DIV))
        else $error("capture did not start divide");

    // last divider step leads to result load
    a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_last) |=> (state_reg == ST_DONE))
        else $error("divide end did not reach done");

    // no result load outside done
    a_finish_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (state_reg == ST_DONE) && !in_ready)
        else $error("result load outside done state");

endmodule

[sv/i2sfd_dp.sv]
`timescale 1ns / 1ps
// i2sfd_dp: edge counters, rate scaling multiply, serial divider, band
// lookup and result register; depends on i2sfd_pkg

module i2sfd_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  i2sfd_pkg::cmd_t                  cmd,
    output i2sfd_pkg::status_t               status,
    input  logic                             bit_clock_edge,
    input  logic                             word_select_edge,
    input  logic                             cfg_we,
    input  logic [i2sfd_pkg::WPS_W-1:0]      cfg_wdata,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [i2sfd_pkg::RATE_W-1:0]     sample_rate_hz,
    output logic [i2sfd_pkg::BITS_W-1:0]     bits_per_sample,
    output logic                             changed
);
    import i2sfd_pkg::*;

    logic [WPS_W-1:0]       wps_reg;
    logic [COUNT_WIDTH-1:0] bc_reg, bc_next;
    logic [COUNT_WIDTH-1:0] ws_reg, ws_next;
    logic [COUNT_WIDTH-1:0] ws_snap_reg;
    logic [COUNT_WIDTH-1:0] quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH:0]   trial;
    logic                   trial_ge;
    logic [STEP_W-1:0]      step_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [RATE_W-1:0]      rate_calc;
    logic [BITS_W-1:0]      bits_calc;
    logic [RATE_W-1:0]      last_rate_reg;
    logic [BITS_W-1:0]      last_bits_reg;
    logic [RATE_W-1:0]      rate_out_reg;
    logic [BITS_W-1:0]      bits_out_reg;
    logic                   changed_out_reg;
    logic                   out_valid_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wps_reg <= WPS_RESET;
        else if (cfg_we)
            wps_reg <= cfg_wdata;
    end

    // saturating edge counts including this tick
    always_comb
    begin
        bc_next = bc_reg;
        ws_next = ws_reg;
        if (cmd.count && bit_clock_edge && bc_reg != '1)
            bc_next = bc_reg + COUNT_WIDTH'(1);
        if (cmd.count && word_select_edge && ws_reg != '1)
            ws_next = ws_reg + COUNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg <= '0;
            ws_reg <= '0;
        end
        else if (cmd.capture)
        begin
            bc_reg <= '0;
            ws_reg <= '0;
        end
        else
        begin
            bc_reg <= bc_next;
            ws_reg <= ws_next;
        end
    end

    // restoring divide, one quotient bit per step
    assign trial    = {rem_reg, quo_reg[COUNT_WIDTH-1]};
    assign trial_ge = (trial >= {1'b0, ws_snap_reg});

    always_comb
    begin
        rem_next = trial[COUNT_WIDTH-1:0];
        if (trial_ge)
            rem_next = COUNT_WIDTH'(trial - {1'b0, ws_snap_reg});
        quo_next = {quo_reg[COUNT_WIDTH-2:0], trial_ge};
    end

    // snapshot, divide and scaling
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ws_snap_reg <= ws_next;
            quo_reg     <= bc_next;
            rem_reg     <= '0;
        end
        else if (cmd.step)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            prod_reg <= PROD_W'(ws_snap_reg) * PROD_W'(wps_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.capture)
            step_reg <= '0;
        else if (cmd.step)
            step_reg <= step_reg + STEP_W'(1);
    end

    assign status.div_last = (step_reg == STEP_W'(COUNT_WIDTH - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    // band lookup on settled product and quotient
    assign rate_calc = rate_band(prod_reg);
    assign bits_calc = (ws_snap_reg == '0) ? BITS_NONE : bits_band(quo_reg);

    // history of the previous window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rate_reg <= '0;
            last_bits_reg <= '0;
        end
        else if (cmd.finish)
        begin
            last_rate_reg <= rate_calc;
            last_bits_reg <= bits_calc;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rate_out_reg    <= rate_calc;
            bits_out_reg    <= bits_calc;
            changed_out_reg <= (rate_calc != last_rate_reg) || (bits_calc != last_bits_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid       = out_valid_reg;
    assign sample_rate_hz  = rate_out_reg;
    assign bits_per_sample = bits_out_reg;
    assign changed         = changed_out_reg;

    // counters restart at zero after a window closes
    a_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (bc_reg == '0) && (ws_reg == '0))
        else $error("edge counters not cleared at window end");

    // result load always raises valid
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result lost after load");

    // loaded bits are one of the quantized values
    a_bits_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (bits_out_reg == BITS_NONE || bits_out_reg == BITS_8 ||
                           bits_out_reg == BITS_16 || bits_out_reg == BITS_24 ||
                           bits_out_reg == BITS_32))
        else $error("illegal bits per sample");

endmodule

[sv/i2s_format_detector_core.sv]
`timescale 1ns / 1ps
// i2s_format_detector_core: top level of the i2s format detector
// depends on i2sfd_pkg, i2sfd_if, i2sfd_ctrl and i2sfd_dp
//
// usage:
//   in_ch carries one tick per transfer: bit clock edge, word select edge and
//   window end. ticks without window end transfer at one per cycle while the
//   block is counting and only bump the saturating edge counters.
//   a tick with window end closes the window: counts (including that tick)
//   are captured and cleared, then a serial divider works out the bit clock
//   to word select ratio, one quotient bit per cycle, while the word select
//   count is scaled by windows_per_second.
//   in_ch.ready stays low after a window end transfer while the divider runs
//   and until the result is loaded into the out_ch result register; the next
//   tick can transfer in the cycle after that load.
//   out_ch has a result register; counting resumes while a result waits.
//   if the receiver stalls and a second window end finishes first, the block
//   holds that result internally and keeps in_ch.ready low until out_ch frees.
//   cfg_we / cfg_wdata write windows_per_second; write only when idle.
//   reset (rst_n low, asynchronous) clears counters and history, sets
//   windows_per_second to 20 and drops out_ch.valid.

module i2s_format_detector_core (
    input  logic                        clk,
    input  logic                        rst_n,
    i2sfd_in_if.sink                    in_ch,
    i2sfd_out_if.source                 out_ch,
    input  logic                        cfg_we,
    input  logic [i2sfd_pkg::WPS_W-1:0] cfg_wdata
);
    import i2sfd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    i2sfd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_window_end (in_ch.window_end),
        .in_ready      (in_ch.ready),
        .status        (status),
        .cmd           (cmd)
    );

    // counters, divider and result register
    i2sfd_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .bit_clock_edge   (in_ch.bit_clock_edge),
        .word_select_edge (in_ch.word_select_edge),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .sample_rate_hz   (out_ch.sample_rate_hz),
        .bits_per_sample  (out_ch.bits_per_sample),
        .changed          (out_ch.changed)
    );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// testbench for i2s_format_detector_core: drives edge ticks and register writes,
// predicts each window result and checks every result transfer
// depends on i2sfd_pkg, i2sfd_if and the detector rtl

module testbench;
    import i2sfd_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 3;
    localparam int PHASE_WINDOWS   = 2;

    // one predicted window result
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [BITS_W-1:0] bits;
        logic              chg;
    } fmt_result_t;

    // predicts window results from accepted ticks and checks result transfers
    class format_scoreboard;
        logic [COUNT_WIDTH-1:0] bclk_count;
        logic [COUNT_WIDTH-1:0] ws_count;
        logic [RATE_W-1:0]      prev_rate;
        logic [BITS_W-1:0]      prev_bits;
        logic [WPS_W-1:0]       wps;
        fmt_result_t            expected_q[$];
        int unsigned            errors;

        function new();
            bclk_count = '0;
            ws_count   = '0;
            prev_rate  = '0;
            prev_bits  = '0;
            wps        = WPS_RESET;
            errors     = 0;
        endfunction

        function void set_wps(input logic [WPS_W-1:0] value);
            wps = value;
        endfunction

        // bands tried in order, so the 48k band wins where it overlaps 88.2k
        function logic [RATE_W-1:0] quantize_rate(input logic [PROD_W-1:0] s);
            if (s >= BAND_11K_LO && s < BAND_16K_LO) return RATE_11K;
            if (s >= BAND_16K_LO && s < BAND_22K_LO) return RATE_16K;
            if (s >= BAND_22K_LO && s < BAND_32K_LO) return RATE_22K;
            if (s >= BAND_32K_LO && s < BAND_44K_LO) return RATE_32K;
            if (s >= BAND_44K_LO && s < BAND_48K_LO) return RATE_44K;
            if (s >= BAND_48K_LO && s < BAND_48K_HI) return RATE_48K;
            if (s >= BAND_88K_LO && s < BAND_96K_LO) return RATE_88K;
            if (s >= BAND_96K_LO) return RATE_96K;
            return RATE_8K;
        endfunction

        function logic [BITS_W-1:0] quantize_bits(input logic [COUNT_WIDTH-1:0] half_ratio);
            if (half_ratio >= RATIO_32) return BITS_32;
            if (half_ratio >= RATIO_24) return BITS_24;
            if (half_ratio >= RATIO_16) return BITS_16;
            return BITS_8;
        endfunction

        // count this tick's edges, then close the window if asked
        function void note_tick(input logic bc, input logic ws, input logic we);
            logic [PROD_W-1:0] scaled;
            fmt_result_t       r;
            if (bc && bclk_count != '1)
                bclk_count = bclk_count + 1'b1;
            if (ws && ws_count != '1)
                ws_count = ws_count + 1'b1;
            if (!we)
                return;
            scaled = PROD_W'(ws_count) * PROD_W'(wps);
            r.rate = quantize_rate(scaled);
            if (ws_count == '0)
                r.bits = BITS_NONE;
            else
                r.bits = quantize_bits(COUNT_WIDTH'(bclk_count / ws_count / 2));
            r.chg = (r.rate != prev_rate) || (r.bits != prev_bits);
            prev_rate = r.rate;
            prev_bits = r.bits;
            expected_q.push_back(r);
            bclk_count = '0;
            ws_count   = '0;
        endfunction

        function void check_result(input logic [RATE_W-1:0] rate,
                                   input logic [BITS_W-1:0] bits,
                                   input logic chg);
            fmt_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with none expected: rate %0d bits %0d changed %0b",
                       rate, bits, chg);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (rate !== e.rate)
            begin
                $error("sample_rate_hz: expected %0d, got %0d", e.rate, rate);
                errors++;
            end
            if (bits !== e.bits)
            begin
                $error("bits_per_sample: expected %0d, got %0d", e.bits, bits);
                errors++;
            end
            if (chg !== e.chg)
            begin
                $error("changed: expected %0b, got %0b", e.chg, chg);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    logic [WPS_W-1:0] cfg_wdata;

    i2sfd_in_if  tick_bus ();
    i2sfd_out_if fmt_bus ();

    format_scoreboard sb;
    bit               idle_en  = 1'b1;
    bit               stall_en = 1'b1;
    bit               hold_req = 1'b0;
    int               quiet_cycles = 0;

    i2s_format_detector_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (tick_bus),
        .out_ch    (fmt_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // transfer monitors and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_bus.valid && tick_bus.ready)
                sb.note_tick(tick_bus.bit_clock_edge, tick_bus.word_select_edge,
                             tick_bus.window_end);
            if (fmt_bus.valid && fmt_bus.ready)
                sb.check_result(fmt_bus.sample_rate_hz, fmt_bus.bits_per_sample,
                                fmt_bus.changed);
            if ((tick_bus.valid && tick_bus.ready) || (fmt_bus.valid && fmt_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no transfer for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result receiver: random stalls, ready stretches and one long hold-off
    initial
    begin
        fmt_bus.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                fmt_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall_en && $urandom_range(0, 2) == 0)
            begin
                fmt_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                fmt_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // one tick transfer, with an optional idle burst ahead of it
    task automatic send_tick(input logic bc, input logic ws, input logic we);
        if (idle_en && $urandom_range(0, 9) == 0)
        begin
            tick_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        tick_bus.valid            <= 1'b1;
        tick_bus.bit_clock_edge   <= bc;
        tick_bus.word_select_edge <= ws;
        tick_bus.window_end       <= we;
        @(posedge clk);
        while (!tick_bus.ready) @(posedge clk);
    endtask

    // stop offering ticks and wait until every result has come back
    task automatic drain_results();
        tick_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wps(input logic [WPS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_wps(value);
    endtask

    // window with exact edge counts, edges packed at the start
    task automatic directed_window(input int wps, input int ws_n, input int bc_n);
        int len;
        if (WPS_W'(wps) != sb.wps)
        begin
            drain_results();
            write_wps(WPS_W'(wps));
        end
        len = (bc_n > ws_n) ? bc_n : ws_n;
        if (len == 0)
            len = 1;
        for (int i = 0; i < len; i++)
            send_tick(i < bc_n, i < ws_n, i == len - 1);
    endtask

    // well-formed window with random content, or a run of noise ticks
    task automatic random_window();
        int ws_n;
        int bc_n;
        int len;
        int sel;
        int rmax;
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 5) == 0);
            return;
        end
        sel = $urandom_range(0, 9);
        if (sel == 0)
            ws_n = 0;
        else if (sel < 6)
            ws_n = $urandom_range(1, 6);
        else
            ws_n = $urandom_range(7, 20);
        if (ws_n == 0)
        begin
            bc_n = $urandom_range(0, 40);
        end
        else
        begin
            rmax = 48 / (2 * ws_n);
            if (rmax > 32)
                rmax = 32;
            bc_n = 2 * ws_n * $urandom_range(0, rmax) + $urandom_range(0, 2 * ws_n + 1);
        end
        len = ((bc_n > ws_n) ? bc_n : ws_n) + $urandom_range(0, 3);
        if (len == 0)
            len = 1;
        for (int i = 0; i < len; i++)
            send_tick($urandom_range(0, len - 1) < bc_n, $urandom_range(0, len - 1) < ws_n,
                      i == len - 1);
    endtask

    // stimulus
    initial
    begin
        int unsigned wps;
        int          len;
        sb = new();
        tick_bus.valid            <= 1'b0;
        tick_bus.bit_clock_edge   <= 1'b0;
        tick_bus.word_select_edge <= 1'b0;
        tick_bus.window_end       <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_wdata                 <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty first window, then the same again with no change
        directed_window(20, 0, 0);
        directed_window(20, 0, 0);
        // bit clock edges only, no word select
        directed_window(20, 0, 7);
        // bits thresholds and truncating divide
        directed_window(1, 3, 71);
        directed_window(1, 1, 44);
        directed_window(1, 1, 52);
        // rate band edge at 48k, then the 48k and 88.2k overlap and its top edge
        directed_window(921, 50, 50);
        directed_window(921, 74, 74);
        directed_window(921, 75, 75);
        // register extremes
        directed_window(0, 5, 10);
        directed_window(1023, 10, 10);

        // random phases, each at its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            case (p)
                0: wps = $urandom_range(600, 1023);
                1: wps = 1000;
                default: wps = $urandom_range(0, 1023);
            endcase
            write_wps(WPS_W'(wps));
            if (p == RANDOM_PHASES - 1)
            begin
                idle_en  = 1'b0;
                stall_en = 1'b0;
            end
            // receiver holds off while short windows pile up
            if (p == 1)
            begin
                idle_en  = 1'b0;
                hold_req = 1'b1;
                for (int w = 0; w < 8; w++)
                begin
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++)
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  i == len - 1);
                end
                idle_en = 1'b1;
            end
            for (int w = 0; w < PHASE_WINDOWS; w++)
                random_window();
        end

        // close any open window and wait for the last results
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
        drain_results();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
sv/i2sfd_pkg.sv
sv/i2sfd_if.sv
sv/i2sfd_ctrl.sv
sv/i2sfd_dp.sv
sv/i2s_format_detector_core.sv
verif/testbench.sv
